### rtl/hpe_pkg.sv
// Shared types and constants for the Horner polynomial evaluation unit.
`default_nettype none

package hpe_pkg;

  localparam int unsigned MAX_TERMS = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned DEG_W   = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [DEG_W-1:0] DEGREE_RESET = 4'd9;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_e;

  typedef struct packed {
    func_e                      func;
    logic [INDEX_W-1:0]         index;
    logic signed [DATA_W-1:0]   value;
    logic signed [DATA_W-1:0]   acc;
    logic                       ovf;
  } item_t;

endpackage

`default_nettype wire

### rtl/hpe_entry.sv
// Entry stage: degree register, coefficient table and initial accumulator.
`default_nettype none

module hpe_entry
  import hpe_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [DEG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  input  wire func_e                in_func_i,
  input  wire logic [INDEX_W-1:0]   in_index_i,
  input  wire logic [DATA_W-1:0]    in_value_i,
  output logic [DEG_W-1:0]          degree_o,
  output logic                      out_valid_o,
  output item_t                     out_item_o
);

  logic [DEG_W-1:0]         degree_q;
  logic [DEG_W-1:0]         deg_clamp;
  logic signed [DATA_W-1:0] coef_q [MAX_TERMS];
  logic signed [DATA_W-1:0] start_coef;
  logic                     valid_q;
  item_t                    item_q;
  logic                     load_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEGREE_RESET;
    end else if (cfg_we_i) begin
      degree_q <= cfg_wdata_i;
    end
  end

  assign deg_clamp = (32'(degree_q) > MAX_TERMS - 1) ? DEG_W'(MAX_TERMS - 1) : degree_q;
  assign degree_o  = deg_clamp;

  assign load_wr = en_i && in_valid_i && (in_func_i == FUNC_LOAD) &&
                   (32'(in_index_i) < MAX_TERMS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < MAX_TERMS; e++) coef_q[e] <= '0;
    end else if (load_wr) begin
      for (int e = 0; e < MAX_TERMS; e++) begin
        if (32'(in_index_i) == e) coef_q[e] <= in_value_i;
      end
    end
  end

  always_comb begin
    start_coef = '0;
    for (int e = 0; e < MAX_TERMS; e++) begin
      if (32'(deg_clamp) == e) start_coef = coef_q[e];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q.func  <= in_func_i;
      item_q.index <= in_index_i;
      item_q.value <= in_value_i;
      item_q.acc   <= start_coef;
      item_q.ovf   <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

### rtl/hpe_step.sv
// One Horner term: multiply stage, then shift, add and saturate stage.
`default_nettype none

module hpe_step
  import hpe_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned COEF_IDX  = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [DEG_W-1:0]   degree_i,
  input  wire logic               in_valid_i,
  input  wire item_t              in_item_i,
  output logic                    out_valid_o,
  output item_t                   out_item_o
);

  logic signed [2*DATA_W-1:0] prod_d, prod_q;
  logic signed [2*DATA_W-1:0] shifted;
  logic signed [2*DATA_W:0]   sum;
  logic signed [DATA_W-1:0]   sat_val;
  logic                       sat_hi, sat_lo;
  logic                       mul_valid_q;
  item_t                      mul_item_q;
  logic signed [DATA_W-1:0]   coef_q;
  logic                       active;
  logic                       add_valid_q;
  item_t                      add_item_d;
  item_t                      add_item_q;

  assign prod_d = in_item_i.acc * in_item_i.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      add_valid_q <= 1'b0;
    end else if (en_i) begin
      mul_valid_q <= in_valid_i;
      add_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_item_q <= in_item_i;
      prod_q     <= prod_d;
    end
  end

  // local copy of this term's coefficient, kept in order with evaluations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (en_i && mul_valid_q && (mul_item_q.func == FUNC_LOAD) &&
                 (32'(mul_item_q.index) == COEF_IDX)) begin
      coef_q <= mul_item_q.value;
    end
  end

  assign shifted = prod_q >>> FRAC_BITS;
  assign sum     = (2*DATA_W+1)'(shifted) + (2*DATA_W+1)'(coef_q);
  assign sat_hi  = sum > (2*DATA_W+1)'(Q_MAX);
  assign sat_lo  = sum < (2*DATA_W+1)'(Q_MIN);

  always_comb begin
    priority if (sat_hi) begin
      sat_val = Q_MAX;
    end else if (sat_lo) begin
      sat_val = Q_MIN;
    end else begin
      sat_val = sum[DATA_W-1:0];
    end
  end

  assign active = (mul_item_q.func == FUNC_EVAL) && (32'(degree_i) > COEF_IDX);

  always_comb begin
    add_item_d = mul_item_q;
    if (active) begin
      add_item_d.acc = sat_val;
      add_item_d.ovf = mul_item_q.ovf | sat_hi | sat_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      add_item_q <= add_item_d;
    end
  end

  assign out_valid_o = add_valid_q;
  assign out_item_o  = add_item_q;

endmodule

`default_nettype wire

### rtl/horner_polynomial_eval_unit.sv
// Top level of the Horner polynomial evaluation unit.
//
//  channel | dir | handshake                    | payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tuser: func; tdata: index, value
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tuser: overflow; tdata: result
//  cfg     | in  | cfg_we_i                     | cfg_wdata_i: degree
//
// One transaction per cycle when the output is taken; the pipeline is the entry stage,
// one multiply and one add stage per lower term, and the output register.
// Every stage advances together; a stalled output holds the whole pipeline.
// Reset clears the coefficient table, all valid bits and sets degree to 9.
// Load transactions flow through the pipeline and update each term's coefficient copy.
`default_nettype none

module horner_polynomial_eval_unit
  import hpe_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [DEG_W-1:0]       cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // index[3:0], value[35:4], zero pad
  input  wire logic                   s_axis_tuser,   // func
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // result[31:0]
  output logic                        m_axis_tuser    // overflow
);

  localparam int unsigned NSTEP = MAX_TERMS - 1;

  logic               en;
  logic [DEG_W-1:0]   degree;
  logic               stage_valid [NSTEP+1];
  item_t              stage_item  [NSTEP+1];
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_data_q;
  logic               out_ovf_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  hpe_entry u_entry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_func_i   (func_e'(s_axis_tuser)),
    .in_index_i  (s_axis_tdata[INDEX_W-1:0]),
    .in_value_i  (s_axis_tdata[INDEX_W+DATA_W-1:INDEX_W]),
    .degree_o    (degree),
    .out_valid_o (stage_valid[0]),
    .out_item_o  (stage_item[0])
  );

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    hpe_step #(
      .FRAC_BITS (FRAC_BITS),
      .COEF_IDX  (NSTEP - 1 - s)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .degree_i    (degree),
      .in_valid_i  (stage_valid[s]),
      .in_item_i   (stage_item[s]),
      .out_valid_o (stage_valid[s+1]),
      .out_item_o  (stage_item[s+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= stage_valid[NSTEP] && (stage_item[NSTEP].func == FUNC_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= stage_item[NSTEP].acc;
      out_ovf_q  <= stage_item[NSTEP].ovf;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

`default_nettype wire

### rtl/hpe_checker.sv
// Port-level assertions for the Horner polynomial evaluation unit, with bind.
`default_nettype none

module hpe_checker
  import hpe_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline stalled");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

endmodule

bind horner_polynomial_eval_unit hpe_checker u_hpe_checker (.*);

`default_nettype wire

### test/horner_polynomial_eval_unit_tb.sv
// Testbench for the Horner polynomial evaluation unit: directed and random traffic with scoreboard.
`timescale 1ns / 100ps

module horner_polynomial_eval_unit_tb;
  import hpe_pkg::*;

  localparam int unsigned NUM_TERMS   = 16;
  localparam int unsigned FRAC        = 16;
  localparam int          DRAIN_CYCLES = 2 * NUM_TERMS + 16;
  localparam int          STALL_LIMIT  = 3000;

  typedef struct {
    logic signed [DATA_W-1:0] result;
    logic                     overflow;
  } poly_value_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b1;
  logic                   cfg_we_i = 1'b0;
  logic [DEG_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // index[3:0], value[35:4], zero pad
  logic                   s_axis_tuser = 1'b0; // func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // result[31:0]
  logic                   m_axis_tuser;        // overflow

  logic signed [DATA_W-1:0] coef_table [NUM_TERMS];
  logic [DEG_W-1:0]         cur_degree = DEGREE_RESET;
  poly_value_t              owed_values [$];
  int                       mismatch_count = 0;
  int                       send_idle_pct = 0;
  int                       recv_idle_pct = 0;
  int                       quiet_cycles = 0;

  horner_polynomial_eval_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Horner's rule with per-step saturation, product and shift exact in 64 bits
  function automatic poly_value_t horner_eval(input logic signed [DATA_W-1:0] x);
    longint      acc;
    longint      sum;
    int          i;
    poly_value_t r;
    r.overflow = 1'b0;
    acc = longint'(coef_table[cur_degree]);
    for (i = int'(cur_degree); i > 0; i--) begin
      sum = ((acc * longint'(x)) >>> FRAC) + longint'(coef_table[i-1]);
      if (sum > longint'(Q_MAX)) begin
        sum = longint'(Q_MAX);
        r.overflow = 1'b1;
      end else if (sum < longint'(Q_MIN)) begin
        sum = longint'(Q_MIN);
        r.overflow = 1'b1;
      end
      acc = sum;
    end
    r.result = 32'(acc);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(input int wide_pct);
    logic signed [DATA_W-1:0] v;
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) begin
      case ($urandom_range(2))
        0:       v = Q_MAX;
        1:       v = Q_MIN;
        default: v = '0;
      endcase
    end else if (sel < 4 + wide_pct) begin
      v = $urandom;
    end else if (sel < 4 + wide_pct + 20) begin
      v = $signed($urandom_range(32'h001F_FFFF)) - 32'sh0010_0000;
    end else begin
      v = $signed($urandom_range(32'h0003_FFFF)) - 32'sh0002_0000;
    end
    return v;
  endfunction

  task automatic send_item(input func_e func, input logic [INDEX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0, value, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == FUNC_LOAD) coef_table[idx] = value;
    else owed_values.push_back(horner_eval(value));
  endtask

  task automatic load_coef(input logic [INDEX_W-1:0] idx, input logic signed [DATA_W-1:0] c);
    send_item(FUNC_LOAD, idx, c);
  endtask

  task automatic eval_at(input logic signed [DATA_W-1:0] x);
    send_item(FUNC_EVAL, INDEX_W'($urandom_range(15)), x);
  endtask

  // loads in flight give no result, so also let the pipeline empty out
  task automatic wait_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (owed_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_degree(input logic [DEG_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_degree = d;
  endtask

  task automatic test_reset_state();
    eval_at(32'sh0001_0000);
    eval_at(Q_MIN);
  endtask

  task automatic test_degree_zero();
    wait_until_drained();
    write_degree(4'd0);
    load_coef(4'd0, 32'sh1234_5678);
    eval_at(Q_MAX);
    eval_at(Q_MIN);
  endtask

  task automatic test_saturation();
    wait_until_drained();
    write_degree(4'd1);
    load_coef(4'd1, Q_MAX);
    load_coef(4'd0, Q_MAX);
    eval_at(32'sh0001_0000);
    eval_at(-32'sh0001_0000);
    load_coef(4'd0, Q_MIN);
    eval_at(-32'sh0001_0000);
    eval_at(Q_MIN);
  endtask

  task automatic test_full_degree();
    wait_until_drained();
    write_degree(4'd15);
    load_coef(4'd15, Q_MAX);
    load_coef(4'd14, Q_MIN);
    load_coef(4'd0, 32'sh0000_8000);
    eval_at(32'sh0001_0000);
    eval_at('0);
    eval_at(-32'sh0000_0001);
  endtask

  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct,
                                     input logic [DEG_W-1:0] deg_a,
                                     input logic [DEG_W-1:0] deg_b);
    int n;
    wait_until_drained();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (n = 0; n < n_items; n++) begin
      if (n == 0 || n == n_items / 2) begin
        wait_until_drained();
        write_degree(n == 0 ? deg_a : deg_b);
      end
      if ($urandom_range(199) == 0) wait_until_drained();
      if ($urandom_range(99) < 35) load_coef(INDEX_W'($urandom_range(15)), pick_value(40));
      else eval_at(pick_value(15));
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    poly_value_t exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_values.size() == 0) begin
        $error("unexpected result transaction: result %h overflow %b",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        exp_v = owed_values.pop_front();
        if (m_axis_tdata !== exp_v.result) begin
          $error("result: expected %h, got %h", exp_v.result, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== exp_v.overflow) begin
          $error("overflow: expected %b, got %b", exp_v.overflow, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    foreach (coef_table[i]) coef_table[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 19;
    recv_idle_pct = 74;
    test_reset_state();
    test_degree_zero();
    test_saturation();
    test_full_degree();
    test_random_traffic(460, 19, 74, DEG_W'($urandom_range(1, 8)), 4'd15);
    test_random_traffic(460, 74, 19, 4'd0, DEG_W'($urandom_range(2, 14)));
    test_random_traffic(460, 0, 0, DEG_W'($urandom_range(15)), 4'd9);
    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hpe_pkg.sv
rtl/hpe_entry.sv
rtl/hpe_step.sv
rtl/horner_polynomial_eval_unit.sv
rtl/hpe_checker.sv
test/horner_polynomial_eval_unit_tb.sv
